// ===== hw/rtl/slb_pkg.sv =====
package slb_pkg;

    // Store geometry
    localparam int STORE_DEPTH = 512;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    // Cursor spans -1 .. STORE_DEPTH, so one extra magnitude bit plus a sign bit
    localparam int CUR_W       = ADDR_W + 2;
    localparam int READ_W      = 6;
    localparam int SHOWN_W     = 9;
    localparam int UNITS_W     = 3;
    localparam int TENTHS_W    = 4;

    typedef logic signed [CUR_W-1:0] cursor_t;
    typedef logic [READ_W-1:0]       reading_t;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_PLUS   = 2'd1,
        MODE_LEFT   = 2'd2,
        MODE_RIGHT  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STAT_STORED = 3'd0,
        STAT_FULL   = 3'd1,
        STAT_SHOW   = 3'd2,
        STAT_NONE   = 3'd3,
        STAT_IDLE   = 3'd4
    } status_t;

    localparam cursor_t CUR_DEPTH = cursor_t'(STORE_DEPTH);
    localparam cursor_t CUR_ONE   = cursor_t'(1);
    localparam cursor_t CUR_NEG1  = cursor_t'(-1);
    localparam cursor_t CUR_ZERO  = cursor_t'(0);

    // Scale a raw 8-bit sample to tenths of a volt: sample*50/255, truncated.
    // Divide by 255 through the reciprocal 257/65536, then fix the one-low case.
    function automatic reading_t scale_sample(input logic [7:0] raw);
        logic [13:0] prod;
        logic [21:0] recip;
        logic [5:0]  quot;
        logic [13:0] back;
        logic [13:0] rem;
        begin
            prod  = 14'(raw) * 14'd50;
            recip = 22'(prod) * 22'd257;
            quot  = recip[21:16];
            back  = 14'(quot) * 14'd255;
            rem   = prod - back;
            if (rem >= 14'd255)
            begin
                quot = quot + 6'd1;
            end
            scale_sample = quot;
        end
    endfunction

    // Whole-volts digit: v/10 as (v*205)>>11, exact for v below 64
    function automatic logic [UNITS_W-1:0] volts_digit(input reading_t v);
        logic [13:0] prod;
        begin
            prod        = 14'(v) * 14'd205;
            volts_digit = UNITS_W'(prod[13:11]);
        end
    endfunction

    // Tenths digit: remainder after the whole volts
    function automatic logic [TENTHS_W-1:0] tenths_digit(input reading_t v);
        logic [UNITS_W-1:0] u;
        logic [6:0]         tens;
        logic [6:0]         diff;
        begin
            u            = volts_digit(v);
            tens         = 7'(u) * 7'd10;
            diff         = 7'(v) - tens;
            tenths_digit = diff[TENTHS_W-1:0];
        end
    endfunction

endpackage

// ===== hw/rtl/slb_ram.sv =====
module slb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port: write, or read with registered data that holds until the next read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/sample_logger_with_browse.sv =====
// Channel | Handshake                | Payload
// input   | in_valid / in_stall      | mode[1:0], sample[7:0]
// output  | out_valid / out_stall    | status[2:0], shown_address[8:0], volts_units[2:0],
//         |                          | volts_tenths[3:0], browsing
//
// Each item passes through S_ACCEPT and S_RESOLVE: the accept cycle updates cursor and mode
// and issues at most one store access (write of the scaled sample or read of the shown
// entry); S_RESOLVE then takes the registered read data, splits it into digits and loads
// the result beat. A result waiting under out_stall does not block the next accept; that
// item waits in S_RESOLVE until the output register frees.
// rst_n clears cursor, last entry, browse mode and the handshake; the store is not cleared.
module sample_logger_with_browse (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    input  logic [7:0] sample,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output logic [8:0] shown_address,
    output logic [2:0] volts_units,
    output logic [3:0] volts_tenths,
    output logic       browsing
);

    typedef enum logic {
        S_ACCEPT,
        S_RESOLVE
    } state_t;

    state_t                              state_reg, state_next;
    slb_pkg::cursor_t                    cursor_reg, cursor_next;
    slb_pkg::cursor_t                    last_reg, last_next;
    logic                                browse_reg, browse_next;
    slb_pkg::status_t                    pend_status_reg, pend_status_next;
    logic [slb_pkg::SHOWN_W-1:0]         pend_addr_reg, pend_addr_next;
    logic                                out_valid_reg, out_valid_next;
    slb_pkg::status_t                    status_reg, status_next;
    logic [slb_pkg::SHOWN_W-1:0]         shown_reg, shown_next;
    logic [slb_pkg::UNITS_W-1:0]         units_reg, units_next;
    logic [slb_pkg::TENTHS_W-1:0]        tenths_reg, tenths_next;
    logic                                browsing_reg, browsing_next;

    logic                                accept;
    logic                                out_free;
    slb_pkg::mode_t                      mode_in;
    slb_pkg::cursor_t                    cur_dec;
    slb_pkg::cursor_t                    cur_inc;
    slb_pkg::cursor_t                    last_inc;
    logic                                ram_en;
    logic                                ram_we;
    logic [slb_pkg::ADDR_W-1:0]          ram_addr;
    slb_pkg::reading_t                   ram_wdata;
    slb_pkg::reading_t                   ram_rdata;

    slb_ram #(
        .WIDTH (slb_pkg::READ_W),
        .DEPTH (slb_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign accept    = in_valid && (state_reg == S_ACCEPT);
    assign out_free  = !out_valid_reg || !out_stall;
    assign mode_in   = slb_pkg::mode_t'(mode);
    assign cur_dec   = cursor_reg - slb_pkg::CUR_ONE;
    assign cur_inc   = cursor_reg + slb_pkg::CUR_ONE;
    assign last_inc  = last_reg + slb_pkg::CUR_ONE;
    assign ram_wdata = slb_pkg::scale_sample(sample);

    // Decode the accepted beat, step the cursor, issue any store access and load the result beat
    always_comb
    begin
        state_next       = state_reg;
        cursor_next      = cursor_reg;
        last_next        = last_reg;
        browse_next      = browse_reg;
        pend_status_next = pend_status_reg;
        pend_addr_next   = pend_addr_reg;
        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        shown_next       = shown_reg;
        units_next       = units_reg;
        tenths_next      = tenths_reg;
        browsing_next    = browsing_reg;
        ram_en           = 1'b0;
        ram_we           = 1'b0;
        ram_addr         = cursor_reg[slb_pkg::ADDR_W-1:0];

        unique case (state_reg)
            S_ACCEPT:
            begin
                if (accept)
                begin
                    state_next       = S_RESOLVE;
                    pend_status_next = slb_pkg::STAT_IDLE;
                    pend_addr_next   = '0;
                    case (mode_in)
                        slb_pkg::MODE_SAMPLE:
                        begin
                            if (!browse_reg)
                            begin
                                if (cursor_reg >= slb_pkg::CUR_DEPTH)
                                begin
                                    cursor_next      = slb_pkg::CUR_DEPTH;
                                    pend_status_next = slb_pkg::STAT_FULL;
                                end
                                else
                                begin
                                    ram_en           = 1'b1;
                                    ram_we           = 1'b1;
                                    cursor_next      = cur_inc;
                                    pend_status_next = slb_pkg::STAT_STORED;
                                end
                            end
                        end
                        slb_pkg::MODE_PLUS:
                        begin
                            if (!browse_reg)
                            begin
                                browse_next = 1'b1;
                                if (cur_dec < slb_pkg::CUR_ZERO)
                                begin
                                    cursor_next      = slb_pkg::CUR_NEG1;
                                    last_next        = slb_pkg::CUR_NEG1;
                                    pend_status_next = slb_pkg::STAT_NONE;
                                end
                                else
                                begin
                                    cursor_next      = cur_dec;
                                    last_next        = cur_dec;
                                    ram_en           = 1'b1;
                                    ram_addr         = cur_dec[slb_pkg::ADDR_W-1:0];
                                    pend_addr_next   = slb_pkg::SHOWN_W'(unsigned'(cur_dec));
                                    pend_status_next = slb_pkg::STAT_SHOW;
                                end
                            end
                            else
                            begin
                                browse_next = 1'b0;
                                cursor_next = slb_pkg::CUR_ZERO;
                                last_next   = slb_pkg::CUR_ZERO;
                            end
                        end
                        slb_pkg::MODE_LEFT:
                        begin
                            if (browse_reg)
                            begin
                                if (cur_dec < slb_pkg::CUR_ZERO)
                                begin
                                    cursor_next      = slb_pkg::CUR_NEG1;
                                    pend_status_next = slb_pkg::STAT_NONE;
                                end
                                else
                                begin
                                    cursor_next      = cur_dec;
                                    ram_en           = 1'b1;
                                    ram_addr         = cur_dec[slb_pkg::ADDR_W-1:0];
                                    pend_addr_next   = slb_pkg::SHOWN_W'(unsigned'(cur_dec));
                                    pend_status_next = slb_pkg::STAT_SHOW;
                                end
                            end
                        end
                        default:
                        begin
                            if (browse_reg)
                            begin
                                if (cur_inc > last_reg)
                                begin
                                    cursor_next      = last_inc;
                                    pend_status_next = slb_pkg::STAT_NONE;
                                end
                                else
                                begin
                                    cursor_next      = cur_inc;
                                    ram_en           = 1'b1;
                                    ram_addr         = cur_inc[slb_pkg::ADDR_W-1:0];
                                    pend_addr_next   = slb_pkg::SHOWN_W'(unsigned'(cur_inc));
                                    pend_status_next = slb_pkg::STAT_SHOW;
                                end
                            end
                        end
                    endcase
                end
            end
            S_RESOLVE:
            begin
                // Load the result beat once the output register frees
                if (out_free)
                begin
                    state_next     = S_ACCEPT;
                    out_valid_next = 1'b1;
                    status_next    = pend_status_reg;
                    browsing_next  = browse_reg;
                    if (pend_status_reg == slb_pkg::STAT_SHOW)
                    begin
                        shown_next  = pend_addr_reg;
                        units_next  = slb_pkg::volts_digit(ram_rdata);
                        tenths_next = slb_pkg::tenths_digit(ram_rdata);
                    end
                    else
                    begin
                        shown_next  = '0;
                        units_next  = '0;
                        tenths_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_ACCEPT;
            end
        endcase
    end

    // Hold state, cursor and the registered result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_ACCEPT;
            cursor_reg      <= slb_pkg::CUR_ZERO;
            last_reg        <= slb_pkg::CUR_ZERO;
            browse_reg      <= 1'b0;
            pend_status_reg <= slb_pkg::STAT_IDLE;
            pend_addr_reg   <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= slb_pkg::STAT_IDLE;
            shown_reg       <= '0;
            units_reg       <= '0;
            tenths_reg      <= '0;
            browsing_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cursor_reg      <= cursor_next;
            last_reg        <= last_next;
            browse_reg      <= browse_next;
            pend_status_reg <= pend_status_next;
            pend_addr_reg   <= pend_addr_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            shown_reg       <= shown_next;
            units_reg       <= units_next;
            tenths_reg      <= tenths_next;
            browsing_reg    <= browsing_next;
        end
    end

    assign in_stall      = (state_reg != S_ACCEPT);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign shown_address = shown_reg;
    assign volts_units   = units_reg;
    assign volts_tenths  = tenths_reg;
    assign browsing      = browsing_reg;

    // Cursor stays within -1 .. depth
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_reg >= slb_pkg::CUR_NEG1) && (cursor_reg <= slb_pkg::CUR_DEPTH))
        else $error("cursor out of range");

    // While browsing the cursor never passes one beyond the last entry
    a_browse_bound: assert property (@(posedge clk) disable iff (!rst_n)
        browse_reg |-> (cursor_reg <= last_inc))
        else $error("cursor beyond last stored entry");

    // While recording the last entry is cleared and the cursor is not negative
    a_record_state: assert property (@(posedge clk) disable iff (!rst_n)
        !browse_reg |-> ((last_reg == slb_pkg::CUR_ZERO) && (cursor_reg >= slb_pkg::CUR_ZERO)))
        else $error("recording state inconsistent");

    // A shown reading is only ever reported in browse mode
    a_show_browsing: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == slb_pkg::STAT_SHOW)) |-> browsing_reg)
        else $error("reading shown while recording");

    // A result beat is loaded only from the resolve cycle
    a_load_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> ($past(state_reg) == S_RESOLVE))
        else $error("result loaded outside resolve");

endmodule
